@@ src/geo_hav_pkg.sv @@
// ============================================================================
// geo_hav_pkg
// Shared constants, widths and helper functions for the haversine geofence
// check pipeline.
// ============================================================================
package geo_hav_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_N = (CORDIC_STEPS < 1) ? 1 :
                              ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS);

    // datapath widths
    localparam int XW = 44;     // cordic x/y, Q40
    localparam int ZW = 34;     // cordic angle, Q30
    localparam int SQ_STEPS = 32;
    localparam int QW = 46 - CORDIC_N;  // quotient bits of the residual divide

    localparam int ROT_LAT = CORDIC_N + 3;
    localparam int SQ_LAT = SQ_STEPS + 1;
    localparam int LAT = 53 + 2 * CORDIC_N + QW;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 44'sd667681663046;
    localparam logic [31:0] ANG_K = 32'd4024455254;
    localparam logic [32:0] FULL_TURN = 33'd3600000000;
    localparam logic [32:0] HALF_TURN = 33'd1800000000;
    localparam logic [30:0] QUARTER_TURN = 31'd900000000;
    localparam logic [26:0] MM_MULT = 27'd99546875;
    localparam logic [34:0] DIST_MAX = 35'd20015087000;
    localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;

    localparam logic signed [30:0] CENTER_LAT_RST = -31'sd58231800;
    localparam logic signed [31:0] CENTER_LON_RST = -32'sd352051400;
    localparam logic [31:0] RADIUS_RST = 32'd8000;

    typedef enum logic [1:0] {
        REG_CENTER_LAT = 2'd0,
        REG_CENTER_LON = 2'd1,
        REG_RADIUS_MM  = 2'd2
    } cfg_reg_t;

    // atan(2^-i) in q30 radians, truncated
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                0:  r = 34'sd843314856;
                1:  r = 34'sd497837829;
                2:  r = 34'sd263043836;
                3:  r = 34'sd133525158;
                4:  r = 34'sd67021686;
                5:  r = 34'sd33543515;
                6:  r = 34'sd16775850;
                7:  r = 34'sd8388437;
                8:  r = 34'sd4194282;
                9:  r = 34'sd2097149;
                10: r = 34'sd1048575;
                11: r = 34'sd524287;
                12: r = 34'sd262143;
                13: r = 34'sd131071;
                14: r = 34'sd65535;
                15: r = 34'sd32767;
                16: r = 34'sd16383;
                17: r = 34'sd8191;
                18: r = 34'sd4095;
                19: r = 34'sd2047;
                20: r = 34'sd1023;
                21: r = 34'sd511;
                22: r = 34'sd255;
                23: r = 34'sd127;
                24: r = 34'sd63;
                25: r = 34'sd31;
                26: r = 34'sd15;
                27: r = 34'sd7;
                28: r = 34'sd3;
                29: r = 34'sd1;
                default: r = '0;
            endcase
            atan_q30 = r;
        end
    endfunction

    // q40 to q31 with rounding, clamped to [0, 1.0]
    function automatic logic [31:0] to_q31(input logic signed [47:0] v);
        logic signed [47:0] t;
        logic [31:0] r;
        begin
            t = (v + 48'sd256) >>> 9;
            if (t[47])
                r = '0;
            else if (t > 48'sd2147483648)
                r = 32'h8000_0000;
            else
                r = t[31:0];
            to_q31 = r;
        end
    endfunction

endpackage

@@ src/geo_hav_rot.sv @@
// ============================================================================
// geo_hav_rot
// Pipelined rotation-mode cordic: one iteration per stage, then a first-order
// residual angle correction and rounding of sine and cosine to q31.
// ============================================================================
module geo_hav_rot (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [geo_hav_pkg::ZW-1:0] z_in,
    input  logic                             tag_in,
    output logic [31:0]                      cos_q31,
    output logic [31:0]                      sin_q31,
    output logic                             tag_out
);
    import geo_hav_pkg::*;

    logic signed [XW-1:0] x_reg [CORDIC_N+1];
    logic signed [XW-1:0] y_reg [CORDIC_N+1];
    logic signed [ZW-1:0] z_reg [CORDIC_N+1];
    logic                 tag_reg [CORDIC_N+1];

    logic signed [XW-11:0] xh;
    logic signed [XW-11:0] yh;
    logic signed [67:0]    pc;
    logic signed [67:0]    ps;

    logic signed [XW-1:0] xm_reg;
    logic signed [XW-1:0] ym_reg;
    logic signed [47:0]   cc_reg;
    logic signed [47:0]   cs_reg;
    logic                 tagm_reg;

    logic [31:0] cos_reg;
    logic [31:0] sin_reg;
    logic        tagq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_in;
            tag_reg[0] <= tag_in;
            for (int i = 0; i < CORDIC_N; i++)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    // residual angle correction, uses the old x and y
    assign xh = x_reg[CORDIC_N][XW-1:10];
    assign yh = y_reg[CORDIC_N][XW-1:10];
    assign pc = 68'(yh) * 68'(z_reg[CORDIC_N]);
    assign ps = 68'(xh) * 68'(z_reg[CORDIC_N]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm_reg   <= x_reg[CORDIC_N];
            ym_reg   <= y_reg[CORDIC_N];
            cc_reg   <= pc[67:20];
            cs_reg   <= ps[67:20];
            tagm_reg <= tag_reg[CORDIC_N];
            cos_reg  <= to_q31($signed({{(48-XW){xm_reg[XW-1]}}, xm_reg}) - cc_reg);
            sin_reg  <= to_q31($signed({{(48-XW){ym_reg[XW-1]}}, ym_reg}) + cs_reg);
            tagq_reg <= tagm_reg;
        end
    end

    assign cos_q31 = cos_reg;
    assign sin_q31 = sin_reg;
    assign tag_out = tagq_reg;

endmodule

@@ src/geo_hav_sqrt.sv @@
// ============================================================================
// geo_hav_sqrt
// Pipelined integer floor square root of a 63-bit value, one result bit per
// stage.
// ============================================================================
module geo_hav_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] val,
    output logic [31:0] root
);
    import geo_hav_pkg::*;

    logic [63:0] rem_reg [SQ_STEPS+1];
    logic [63:0] res_reg [SQ_STEPS+1];

    always_ff @(posedge clk)
    begin : p_sqrt
        logic [63:0] bitv;
        logic [63:0] trial;
        if (en)
        begin
            rem_reg[0] <= {1'b0, val};
            res_reg[0] <= '0;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                bitv  = 64'd1 << (62 - 2 * k);
                trial = res_reg[k] + bitv;
                if (rem_reg[k] >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    res_reg[k+1] <= (res_reg[k] >> 1) + bitv;
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    assign root = res_reg[SQ_STEPS][31:0];

endmodule

@@ src/geofence_haversine_check.sv @@
// ============================================================================
// geofence_haversine_check
// Haversine great-circle distance from a position fix to the fence centre,
// in millimetres, with an outside flag against the fence radius.
// ============================================================================
//
//  channel   signals                                    direction
//  -------   ----------------------------------------   ---------
//  in        in_valid/in_ready, current_lat/lon          input
//  out       out_valid/out_ready, distance_mm, outside   output
//  cfg       cfg_we, cfg_index, cfg_data                 input
//
//  one transaction per cycle while the output is not held; the latency is set
//  by the four parallel rotation cordics, the two 32-stage square roots, the
//  vectoring cordic and the residual divider.
//  reset clears the stage valid bits and loads the default fence.
//  a held result freezes every stage; nothing is dropped or repeated.
//
module geofence_haversine_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [30:0] current_lat,
    input  logic signed [31:0] current_lon,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [34:0]        distance_mm,
    output logic               outside,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import geo_hav_pkg::*;

    localparam int ST_A = 12 + CORDIC_N;

    logic signed [30:0] center_lat_reg;
    logic signed [31:0] center_lon_reg;
    logic [31:0]        radius_reg;

    logic [LAT-1:0] vld_reg;
    logic           adv;

    // front end: differences, folding, angle scaling
    logic signed [31:0] dlat_reg;
    logic signed [32:0] dlon_reg;
    logic signed [30:0] lat1_reg;
    logic signed [30:0] lat2_reg;
    logic signed [32:0] sv [4];
    logic [32:0] mag_reg [4];
    logic [31:0] md_reg [4];
    logic [30:0] fd_reg [4];
    logic [30:0] e_reg [4];
    logic        neg4_reg [4];
    logic [62:0] prod_reg [4];
    logic        neg5_reg [4];

    logic signed [ZW-1:0] rz [4];
    logic [31:0] rc [4];
    logic [31:0] rs [4];
    logic        rtag [4];

    // haversine term
    logic [31:0]        sh_reg;
    logic [31:0]        sl_reg;
    logic signed [32:0] c1_reg;
    logic signed [32:0] c2_reg;
    logic signed [65:0] p1;
    logic signed [65:0] p2;
    logic [63:0]        sq_sh;
    logic [62:0]        a0_reg;
    logic signed [32:0] u_reg;
    logic signed [32:0] v_reg;
    logic signed [65:0] pb;
    logic [62:0]        a1_reg;
    logic signed [63:0] b_reg;
    logic signed [64:0] asum;
    logic [62:0]        a_reg;
    logic [62:0]        na;
    logic [31:0]        sq_a;
    logic [31:0]        sq_na;

    // vectoring cordic
    logic signed [XW-1:0] vx_reg [CORDIC_N+1];
    logic signed [XW-1:0] vy_reg [CORDIC_N+1];
    logic signed [ZW-1:0] vz_reg [CORDIC_N+1];

    // residual divide
    logic [XW-1:0] yabs;
    logic          xpos;
    logic [63:0]   drem_reg [QW+1];
    logic [23:0]   ddvs_reg [QW+1];
    logic [QW-1:0] dq_reg [QW+1];
    logic          dneg_reg [QW+1];
    logic          dzero_reg [QW+1];
    logic signed [ZW-1:0] dz_reg [QW+1];

    // tail
    logic signed [QW:0]   qs_reg;
    logic signed [ZW-1:0] fz_reg;
    logic signed [ZW+10:0] zsum;
    logic [43:0]          zf_reg;
    logic [50:0]          hi_reg;
    logic [46:0]          lo_reg;
    logic [47:0]          tlow;
    logic [38:0]          dsum;
    logic [34:0]          d_reg;
    logic [34:0]          dist_reg;
    logic                 outside_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_lat_reg <= CENTER_LAT_RST;
            center_lon_reg <= CENTER_LON_RST;
            radius_reg     <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_LAT: center_lat_reg <= cfg_data[30:0];
                REG_CENTER_LON: center_lon_reg <= cfg_data;
                REG_RADIUS_MM:  radius_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // valid bits and global stall
    // ------------------------------------------------------------------
    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // front end
    // ------------------------------------------------------------------
    // lanes: 0 lat difference, 1 lon difference, 2 fix lat, 3 centre lat
    assign sv[0] = $signed({dlat_reg[31], dlat_reg});
    assign sv[1] = dlon_reg;
    assign sv[2] = $signed({{2{lat1_reg[30]}}, lat1_reg});
    assign sv[3] = $signed({{2{lat2_reg[30]}}, lat2_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlat_reg <= $signed({center_lat_reg[30], center_lat_reg})
                      - $signed({current_lat[30], current_lat});
            dlon_reg <= $signed({center_lon_reg[31], center_lon_reg})
                      - $signed({current_lon[31], current_lon});
            lat1_reg <= current_lat;
            lat2_reg <= center_lat_reg;
            for (int g = 0; g < 4; g++)
            begin
                mag_reg[g] <= sv[g][32] ? 33'(-sv[g]) : 33'(sv[g]);
                md_reg[g]  <= (mag_reg[g] >= FULL_TURN) ? 32'(mag_reg[g] - FULL_TURN)
                                                        : mag_reg[g][31:0];
                fd_reg[g]  <= ({1'b0, md_reg[g]} > HALF_TURN)
                              ? 31'(FULL_TURN - {1'b0, md_reg[g]}) : md_reg[g][30:0];
                if (g >= 2 && fd_reg[g] > QUARTER_TURN)
                begin
                    neg4_reg[g] <= 1'b1;
                    e_reg[g]    <= 31'(HALF_TURN - {2'b0, fd_reg[g]});
                end
                else
                begin
                    neg4_reg[g] <= 1'b0;
                    e_reg[g]    <= fd_reg[g];
                end
                prod_reg[g] <= 63'(e_reg[g]) * 63'(ANG_K);
                neg5_reg[g] <= neg4_reg[g];
            end
        end
    end

    // half angles for the sine lanes, full angles for the cosine lanes
    generate
        for (genvar g = 0; g < 4; g++)
        begin : g_rot
            logic [63:0] zr;
            if (g < 2)
            begin : g_half
                assign zr    = {1'b0, prod_reg[g]} + 64'h8000_0000;
                assign rz[g] = $signed({2'b00, zr[63:32]});
            end
            else
            begin : g_full
                assign zr    = {1'b0, prod_reg[g]} + 64'h4000_0000;
                assign rz[g] = $signed({1'b0, zr[63:31]});
            end

            geo_hav_rot u_rot (
                .clk     (clk),
                .en      (adv),
                .z_in    (rz[g]),
                .tag_in  (neg5_reg[g]),
                .cos_q31 (rc[g]),
                .sin_q31 (rs[g]),
                .tag_out (rtag[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2)
    // ------------------------------------------------------------------
    assign p1    = 66'(c1_reg) * 66'($signed({1'b0, sl_reg}));
    assign p2    = 66'(c2_reg) * 66'($signed({1'b0, sl_reg}));
    assign sq_sh = 64'(sh_reg) * 64'(sh_reg);
    assign pb    = 66'(u_reg) * 66'(v_reg);
    assign asum  = $signed({2'b00, a1_reg}) + $signed({b_reg[63], b_reg});
    assign na    = ONE_Q62 - a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sh_reg <= rs[0];
            sl_reg <= rs[1];
            c1_reg <= rtag[2] ? -$signed({1'b0, rc[2]}) : $signed({1'b0, rc[2]});
            c2_reg <= rtag[3] ? -$signed({1'b0, rc[3]}) : $signed({1'b0, rc[3]});
            a0_reg <= sq_sh[62:0];
            u_reg  <= p1[63:31];
            v_reg  <= p2[63:31];
            a1_reg <= a0_reg;
            b_reg  <= pb[63:0];
            if (asum[64])
                a_reg <= '0;
            else if (asum > $signed({2'b00, ONE_Q62}))
                a_reg <= ONE_Q62;
            else
                a_reg <= asum[62:0];
        end
    end

    geo_hav_sqrt u_sqrt_a (
        .clk  (clk),
        .en   (adv),
        .val  (a_reg),
        .root (sq_a)
    );

    geo_hav_sqrt u_sqrt_na (
        .clk  (clk),
        .en   (adv),
        .val  (na),
        .root (sq_na)
    );

    // ------------------------------------------------------------------
    // vectoring cordic: angle of (sqrt(1-a), sqrt(a))
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg[0] <= $signed({3'b000, sq_na, 9'b0});
            vy_reg[0] <= $signed({3'b000, sq_a, 9'b0});
            vz_reg[0] <= '0;
            for (int i = 0; i < CORDIC_N; i++)
            begin
                if (!vy_reg[i][XW-1])
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + atan_q30(i);
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - atan_q30(i);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // residual y*2^20 / (x>>20), truncating toward zero
    // ------------------------------------------------------------------
    assign xpos = !vx_reg[CORDIC_N][XW-1] && (vx_reg[CORDIC_N] != '0);
    assign yabs = vy_reg[CORDIC_N][XW-1] ? XW'(-vy_reg[CORDIC_N])
                                         : XW'(vy_reg[CORDIC_N]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drem_reg[0]  <= {yabs, 20'b0};
            ddvs_reg[0]  <= xpos ? vx_reg[CORDIC_N][XW-1:20] : '0;
            dzero_reg[0] <= !xpos || (vx_reg[CORDIC_N][XW-1:20] == '0);
            dneg_reg[0]  <= vy_reg[CORDIC_N][XW-1];
            dq_reg[0]    <= '0;
            dz_reg[0]    <= vz_reg[CORDIC_N];
            for (int j = 0; j < QW; j++)
            begin
                if (drem_reg[j] >= (64'(ddvs_reg[j]) << (QW - 1 - j)))
                begin
                    drem_reg[j+1] <= drem_reg[j] - (64'(ddvs_reg[j]) << (QW - 1 - j));
                    dq_reg[j+1]   <= dq_reg[j] | (QW'(1) << (QW - 1 - j));
                end
                else
                begin
                    drem_reg[j+1] <= drem_reg[j];
                    dq_reg[j+1]   <= dq_reg[j];
                end
                ddvs_reg[j+1]  <= ddvs_reg[j];
                dzero_reg[j+1] <= dzero_reg[j];
                dneg_reg[j+1]  <= dneg_reg[j];
                dz_reg[j+1]    <= dz_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // angle, scaling to millimetres, cap and radius compare
    // ------------------------------------------------------------------
    assign zsum = $signed({fz_reg[ZW-1], fz_reg, 10'b0})
                + $signed({{(ZW+10-QW){qs_reg[QW]}}, qs_reg});
    assign tlow = {15'b0, hi_reg[12:0], 20'b0} + {1'b0, lo_reg} + 48'h1_0000_0000;
    assign dsum = {1'b0, hi_reg[50:13]} + 39'(tlow[47:33]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dzero_reg[QW])
                qs_reg <= '0;
            else if (dneg_reg[QW])
                qs_reg <= -$signed({1'b0, dq_reg[QW]});
            else
                qs_reg <= $signed({1'b0, dq_reg[QW]});
            fz_reg <= dz_reg[QW];
            zf_reg <= zsum[ZW+10] ? '0 : zsum[43:0];
            hi_reg <= 51'(zf_reg[43:20]) * 51'(MM_MULT);
            lo_reg <= 47'(zf_reg[19:0]) * 47'(MM_MULT);
            d_reg  <= (dsum > 39'(DIST_MAX)) ? DIST_MAX : dsum[34:0];
            dist_reg    <= d_reg;
            outside_reg <= d_reg > {3'b000, radius_reg};
        end
    end

    assign distance_mm = dist_reg;
    assign outside     = outside_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_dist_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_mm <= DIST_MAX)
        else $error("distance above cap");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_A] |-> a_reg <= ONE_Q62)
        else $error("haversine term out of range");

endmodule

@@ bench/geofence_haversine_check_tb.sv @@
// ----------------------------------------------------------------------------
// geofence_haversine_check_tb
// Drives position fixes into the haversine geofence check under several fence
// settings and handshake idle patterns. Every returned distance and outside
// flag is compared with a bit-exact fixed-point distance predictor.
// ----------------------------------------------------------------------------
module geofence_haversine_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import geo_hav_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 415;

    typedef struct {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
    } fix_t;

    typedef struct {
        logic [34:0] distance;
        logic        outside;
    } fence_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [30:0] current_lat = '0;
    logic signed [31:0] current_lon = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [34:0]        distance_mm;
    logic               outside;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_CENTER_LAT;
    logic [31:0]        cfg_data = '0;

    // fence setting as seen by the predictor
    logic signed [30:0] fence_lat = CENTER_LAT_RST;
    logic signed [31:0] fence_lon = CENTER_LON_RST;
    logic [31:0]        fence_radius = RADIUS_RST;

    fence_result_t pending_results[$];
    int errors = 0;
    int fixes_sent = 0;
    int results_seen = 0;
    int outside_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    longint signed arctan_tab[32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1, 0, 0};

    geofence_haversine_check DUT (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- distance predictor ----------------
    function automatic longint unsigned fold_angle(longint signed d);
        longint unsigned u;
        u = d < 0 ? 64'(-d) : 64'(d);
        u = u % 64'(FULL_TURN);
        if (u > 64'(HALF_TURN))
            u = 64'(FULL_TURN) - u;
        return u;
    endfunction

    function automatic longint signed q40_to_q31(longint signed v);
        v = (v + 256) >>> 9;
        if (v < 0)
            v = 0;
        if (v > 64'sd2147483648)
            v = 64'sd2147483648;
        return v;
    endfunction

    function automatic void cordic_rotate(longint signed z, output longint signed cq,
                                          output longint signed sq);
        longint signed x, y, nx, c, s;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_tab[i];
            end
            x = nx;
        end
        c = ((y >>> 10) * z) >>> 20;
        s = ((x >>> 10) * z) >>> 20;
        cq = q40_to_q31(x - c);
        sq = q40_to_q31(y + s);
    endfunction

    function automatic longint signed half_sine(longint signed d);
        longint unsigned e;
        longint signed c, s;
        e = fold_angle(d);
        cordic_rotate(longint'((e * 64'(ANG_K) + (64'd1 << 31)) >> 32), c, s);
        return s;
    endfunction

    function automatic longint signed full_cosine(longint signed d);
        longint unsigned e;
        longint signed c, s;
        bit neg;
        e = fold_angle(d);
        neg = e > 64'(QUARTER_TURN);
        if (neg)
            e = 64'(HALF_TURN) - e;
        cordic_rotate(longint'((e * 64'(ANG_K) + (64'd1 << 30)) >> 31), c, s);
        return neg ? -c : c;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b; r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned great_circle_mm(longint signed lat1,
        longint signed lon1, longint signed lat2, longint signed lon2);
        longint signed sh, sl, c1, c2, u, v, b, x, y, z, nx, zf;
        longint unsigned a, xs, zh, zl, hi, lo, d;
        sh = half_sine(lat2 - lat1);
        sl = half_sine(lon2 - lon1);
        c1 = full_cosine(lat1);
        c2 = full_cosine(lat2);
        u = (c1 * sl) >>> 31;
        v = (c2 * sl) >>> 31;
        b = u * v;
        a = 64'(sh * sh);
        if (b >= 0)
            a += 64'(b);
        else
            a = a > 64'(-b) ? a - 64'(-b) : 0;
        if (a > 64'(ONE_Q62))
            a = 64'(ONE_Q62);
        x = longint'(floor_sqrt(64'(ONE_Q62) - a) << 9);
        y = longint'(floor_sqrt(a) << 9);
        z = 0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_tab[i];
            end
            else
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_tab[i];
            end
            x = nx;
        end
        zf = z * 1024;
        xs = x > 0 ? 64'(x) >> 20 : 0;
        if (xs > 0)
            zf += (y * 1048576) / longint'(xs);
        if (zf < 0)
            zf = 0;
        zh = 64'(zf) >> 20;
        zl = 64'(zf) & 64'hFFFFF;
        hi = zh * 64'(MM_MULT);
        lo = zl * 64'(MM_MULT);
        d = (hi >> 13) + ((((hi & 64'h1FFF) << 20) + lo + (64'd1 << 32)) >> 33);
        if (d > 64'(DIST_MAX))
            d = 64'(DIST_MAX);
        return d;
    endfunction

    function automatic fence_result_t predict_fence(fix_t f);
        fence_result_t r;
        longint unsigned d;
        d = great_circle_mm(f.lat, f.lon, fence_lat, fence_lon);
        r.distance = d[34:0];
        r.outside = d > 64'(fence_radius);
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (outside)
                outside_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result distance=%0d", distance_mm));
            else
            begin
                fence_result_t e;
                e = pending_results.pop_front();
                if (distance_mm !== e.distance)
                    report_mismatch($sformatf("distance_mm got %0d exp %0d",
                                              distance_mm, e.distance));
                if (outside !== e.outside)
                    report_mismatch($sformatf("outside got %b exp %b (distance %0d)",
                                              outside, e.outside, e.distance));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CENTER_LAT: fence_lat = val[30:0];
            REG_CENTER_LON: fence_lon = val;
            REG_RADIUS_MM:  fence_radius = val;
            default: ;
        endcase
    endtask

    task automatic set_fence(logic signed [30:0] lat, logic signed [31:0] lon,
                             logic [31:0] rad);
        write_reg(REG_CENTER_LAT, 32'(lat));
        write_reg(REG_CENTER_LON, lon);
        write_reg(REG_RADIUS_MM, rad);
    endtask

    // valid is only lowered when an idle gap is taken
    task automatic send_fix(fix_t f);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        current_lat <= f.lat;
        current_lon <= f.lon;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_fence(f));
        fixes_sent++;
    endtask

    // called right after an accepting edge, so valid drops at once
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LAT + 20) @(posedge clk);
    endtask

    function automatic fix_t random_fix();
        fix_t f;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            // near the fence centre so both flag values show up
            f.lat = fence_lat + 31'(int'($urandom_range(16000)) - 8000);
            f.lon = fence_lon + int'($urandom_range(16000)) - 8000;
        end
        else if (pick < 85)
        begin
            f.lat = 31'(int'($urandom_range(1800000000)) - 900000000);
            f.lon = int'($urandom_range(32'd3600000000) - 32'd1800000000);
        end
        else
        begin
            f.lat = 31'($urandom);
            f.lon = $urandom;
        end
        return f;
    endfunction

    fix_t directed_fixes[] = '{
        '{CENTER_LAT_RST, CENTER_LON_RST},
        '{CENTER_LAT_RST + 31'sd300, CENTER_LON_RST},
        '{CENTER_LAT_RST + 31'sd800, CENTER_LON_RST},
        '{CENTER_LAT_RST, CENTER_LON_RST - 32'sd900},
        '{31'sd900000000, 32'sd0},
        '{-31'sd900000000, 32'sd0},
        '{31'sd1073741823, 32'sd1800000000},
        '{31'sh4000_0000, -32'sd1800000000},
        '{31'sd0, 32'sd2147483647},
        '{31'sd0, 32'sh8000_0000},
        '{31'sd58231800, 32'sd1447948600},
        '{31'sd58231800, 32'sd2142915896},
        '{31'sd0, 32'sd0},
        '{31'sd1000000000, CENTER_LON_RST},
        '{-31'sd1000000000, CENTER_LON_RST + 32'sd1800000000},
        '{CENTER_LAT_RST, CENTER_LON_RST + 32'sd1800000000},
        '{CENTER_LAT_RST, CENTER_LON_RST + 32'sd1900000000}
    };

    initial
    begin
        int pct_send[3] = '{13, 77, 0};
        int pct_recv[3] = '{77, 13, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset fence, directed fixes
        send_idle_pct = 0;
        recv_idle_pct = 30;
        foreach (directed_fixes[i])
            send_fix(directed_fixes[i]);
        drain();

        // fence at the extremes, plus a write to the unused index
        set_fence(31'sd900000000, 32'sd1800000000, 32'd0);
        write_reg(REG_UNUSED, 32'h5A5A_5A5A);
        foreach (directed_fixes[i])
            send_fix(directed_fixes[i]);
        send_fix('{31'sd900000000, 32'sd1800000000});
        drain();
        set_fence(-31'sd900000000, -32'sd1800000000, 32'hFFFF_FFFF);
        foreach (directed_fixes[i])
            send_fix(directed_fixes[i]);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            set_fence(31'(int'($urandom_range(1700000000)) - 850000000),
                      int'($urandom_range(32'd3600000000) - 32'd1800000000),
                      $urandom_range(90000000, 1000));
            send_idle_pct = pct_send[p];
            recv_idle_pct = pct_recv[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == RANDOM_PER_PHASE / 2)
                begin
                    // hold off until the pipeline is empty
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                send_fix(random_fix());
            end
            drain();
        end

        $display("sent %0d fixes, %0d results checked, %0d flagged outside",
                 fixes_sent, results_seen, outside_seen);
        $display("covered reset, extreme and random fences under three idle patterns");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
